[src/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition in one cycle that forces another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/fbe_pkg.sv]
// Types, constants and the round function of the Feistel block cipher.
package fbe_pkg;

    localparam int NUM_ROUNDS = 8;
    localparam int SBOX_ROWS  = 8;
    localparam int HALF_W     = 16;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_ROUND_KEYS_LOW  = 2'd0;
    localparam logic [1:0] REG_ROUND_KEYS_HIGH = 2'd1;
    localparam logic [1:0] REG_WHITENING_KEYS  = 2'd2;

    // S-box: in row i, the column is selected by bits 2i+1:2i of the round function input.
    localparam logic [HALF_W-1:0] SBOX [SBOX_ROWS][4] = '{
        '{16'habcb, 16'h7386, 16'h6ea3, 16'h4128},
        '{16'h689b, 16'h22c7, 16'h532d, 16'ha42b},
        '{16'h0e52, 16'hf025, 16'h8724, 16'h9ac0},
        '{16'h776a, 16'h629f, 16'h4510, 16'h3188},
        '{16'h1111, 16'hda99, 16'h52bc, 16'hdead},
        '{16'hdeaf, 16'hbeef, 16'h5810, 16'h7219},
        '{16'h733b, 16'h5ac7, 16'h2468, 16'h9753},
        '{16'h8263, 16'h820d, 16'he72f, 16'h410c}
    };

    typedef struct packed {
        logic [HALF_W-1:0] left;
        logic [HALF_W-1:0] right;
    } half_pair_t;

    typedef struct packed {
        logic [NUM_ROUNDS-1:0][HALF_W-1:0] round_key;
        logic [HALF_W-1:0]                 white_left;
        logic [HALF_W-1:0]                 white_right;
    } key_set_t;

    // Round function: sum modulo 2^16 of one S-box word per row.
    function automatic logic [HALF_W-1:0] mix_f(input logic [HALF_W-1:0] x);
        logic [HALF_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < SBOX_ROWS; i++) begin
            acc = acc + SBOX[i][x[2*i +: 2]];
        end
        return acc;
    endfunction

endpackage

[src/fbe_cfg_regs.sv]
// APB-style configuration registers holding the round and whitening keys.
module fbe_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    output fbe_pkg::key_set_t keys
);
    import fbe_pkg::*;

    logic [63:0] round_keys_low_reg;
    logic [63:0] round_keys_high_reg;
    logic [31:0] whitening_keys_reg;
    logic [1:0]  reg_index;
    logic        write_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:3];
    assign write_en  = psel && penable && pwrite;

    // Register writes; writes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_keys_low_reg  <= '0;
            round_keys_high_reg <= '0;
            whitening_keys_reg  <= '0;
        end
        else if (write_en)
        begin
            unique case (reg_index)
                REG_ROUND_KEYS_LOW:  round_keys_low_reg  <= pwdata;
                REG_ROUND_KEYS_HIGH: round_keys_high_reg <= pwdata;
                REG_WHITENING_KEYS:  whitening_keys_reg  <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb
    begin
        unique case (reg_index)
            REG_ROUND_KEYS_LOW:  prdata = round_keys_low_reg;
            REG_ROUND_KEYS_HIGH: prdata = round_keys_high_reg;
            REG_WHITENING_KEYS:  prdata = {32'd0, whitening_keys_reg};
            default:             prdata = '0;
        endcase
    end

    // Split the key words into one subkey per round.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            keys.round_key[k]     = round_keys_low_reg[HALF_W*k +: HALF_W];
            keys.round_key[k + 4] = round_keys_high_reg[HALF_W*k +: HALF_W];
        end
        keys.white_left  = whitening_keys_reg[15:0];
        keys.white_right = whitening_keys_reg[31:16];
    end

endmodule

[src/fbe_round_cell.sv]
// One Feistel round cell: computes a round and holds the result for its neighbor.
module fbe_round_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [fbe_pkg::HALF_W-1:0]  round_key,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  fbe_pkg::half_pair_t         up_data,
    output logic                        down_valid,
    input  logic                        down_ready,
    output fbe_pkg::half_pair_t         down_data
);
    import fbe_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    half_pair_t        data_reg;
    half_pair_t        data_next;
    logic [HALF_W-1:0] keyed_left;

    // The cell takes a new transaction when it is empty or its content moves on.
    assign up_ready = !valid_reg || down_ready;

    // Round: key the left half, mix it into the right half, then swap.
    always_comb
    begin
        keyed_left      = up_data.left ^ round_key;
        data_next.left  = up_data.right ^ mix_f(keyed_left);
        data_next.right = keyed_left;
        valid_next      = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, loaded only on a transaction.
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

endmodule

[src/fbe_whiten_out.sv]
// Output cell: applies the whitening keys and holds the ciphertext for the consumer.
module fbe_whiten_out (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [fbe_pkg::HALF_W-1:0]  white_left,
    input  logic [fbe_pkg::HALF_W-1:0]  white_right,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  fbe_pkg::half_pair_t         up_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [31:0]                 ciphertext
);
    import fbe_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] cipher_reg;
    logic [31:0] cipher_next;

    assign up_ready = !valid_reg || out_ready;

    // Final whitening and packing of the halves.
    always_comb
    begin
        cipher_next = {up_data.left ^ white_left, up_data.right ^ white_right};
        valid_next  = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            cipher_reg <= cipher_next;
        end
    end

    assign out_valid  = valid_reg;
    assign ciphertext = cipher_reg;

endmodule

[src/feistel_block_encrypt_32.sv]
// Top level of the pipelined 32-bit Feistel block encryption engine.
// The engine accepts one plaintext block per clock cycle while in_ready is
// high. When the consumer keeps up, a block is registered in each of the
// round cells in turn and then in the whitening cell before out_valid for it
// rises. There are eight round cells, one per Feistel round,
// each computing its round and registering the result, followed by a
// whitening cell that serves as the output register. Every cell has its own
// valid bit and a ready that looks only at its downstream neighbor, so empty
// cells fill while a finished ciphertext waits, and input stalls only once
// all nine cells hold blocks. Keys are to be written through the APB port
// only while no block is in flight; the engine does not enforce this.
module feistel_block_encrypt_32 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] plaintext,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] ciphertext
);
    import fbe_pkg::*;

    key_set_t   keys;
    logic       chain_valid [NUM_ROUNDS+1];
    logic       chain_ready [NUM_ROUNDS+1];
    half_pair_t chain_data  [NUM_ROUNDS+1];

    fbe_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .keys    (keys)
    );

    // Input side of the chain.
    assign chain_valid[0]      = in_valid;
    assign in_ready            = chain_ready[0];
    assign chain_data[0].left  = plaintext[31:16];
    assign chain_data[0].right = plaintext[15:0];

    // One cell per round.
    for (genvar g = 0; g < NUM_ROUNDS; g++)
    begin : g_round
        fbe_round_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .round_key  (keys.round_key[g]),
            .up_valid   (chain_valid[g]),
            .up_ready   (chain_ready[g]),
            .up_data    (chain_data[g]),
            .down_valid (chain_valid[g+1]),
            .down_ready (chain_ready[g+1]),
            .down_data  (chain_data[g+1])
        );
    end

    fbe_whiten_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .white_left  (keys.white_left),
        .white_right (keys.white_right),
        .up_valid    (chain_valid[NUM_ROUNDS]),
        .up_ready    (chain_ready[NUM_ROUNDS]),
        .up_data     (chain_data[NUM_ROUNDS]),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ciphertext  (ciphertext)
    );

endmodule

[src/fbe_checker.sv]
// Port-level assertions for the Feistel engine and their binding to the top level.
`include "assert_macros.svh"

module fbe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pready,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] ciphertext
);

    // A consumer that takes results keeps the whole chain moving.
    `ASSERT_ALWAYS(a_ready_follows_out, !out_ready || in_ready, "input stalled while output drains")

    // The configuration port never inserts wait states.
    `ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

    // A stalled result stays offered.
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "out_valid dropped while stalled")

    // A stalled result keeps its value.
    `ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(ciphertext), "ciphertext changed")

endmodule

bind feistel_block_encrypt_32 fbe_checker u_fbe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pready     (pready),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ciphertext (ciphertext)
);

[tb/sv/testbench.sv]
// Self-checking testbench for the pipelined 32-bit Feistel block encryption engine.
module testbench;
    import fbe_pkg::*;

    // Index outside the register map; a write to it must change nothing.
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    localparam int DIRECTED_ROWS    = 25;
    localparam int KEY_PHASES       = 6;
    localparam int BLOCKS_PER_PHASE = 150;
    localparam int PIPE_DEPTH       = 9;
    localparam int MAX_REPORTS      = 10;

    typedef enum logic {ROW_WRITE, ROW_BLOCK} row_kind_t;

    // One row of the directed table: a key write or a plaintext block.
    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  idx;
        logic [63:0] value;
    } stim_row_t;

    // Block in flight together with the ciphertext it must produce.
    typedef struct packed {
        logic [31:0] plain;
        logic [31:0] cipher;
    } cipher_due_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] plaintext;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] ciphertext;

    // Local copy of the key registers.
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [31:0] white_keys;

    cipher_due_t ciphers_due [$];
    cipher_due_t oldest_due;
    int          mismatches;
    bit          in_calm;

    // Block rows carry the plaintext in the value field; their index is unused.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_BLOCK, REG_UNMAPPED,        64'h0000_0000},
        '{ROW_BLOCK, REG_UNMAPPED,        64'hffff_ffff},
        '{ROW_BLOCK, REG_UNMAPPED,        64'hffff_0000},
        '{ROW_BLOCK, REG_UNMAPPED,        64'h0000_ffff},
        '{ROW_BLOCK, REG_UNMAPPED,        64'h8000_0001},
        '{ROW_BLOCK, REG_UNMAPPED,        64'h5555_5555},
        '{ROW_BLOCK, REG_UNMAPPED,        64'haaaa_aaaa},
        '{ROW_WRITE, REG_ROUND_KEYS_LOW,  64'hffff_ffff_ffff_ffff},
        '{ROW_WRITE, REG_ROUND_KEYS_HIGH, 64'hffff_ffff_ffff_ffff},
        '{ROW_WRITE, REG_WHITENING_KEYS,  64'h0000_0000_ffff_ffff},
        '{ROW_BLOCK, REG_UNMAPPED,        64'h0000_0000},
        '{ROW_BLOCK, REG_UNMAPPED,        64'hffff_ffff},
        '{ROW_BLOCK, REG_UNMAPPED,        64'h1234_5678},
        '{ROW_WRITE, REG_WHITENING_KEYS,  64'hdead_beef_0f0f_0f0f},
        '{ROW_BLOCK, REG_UNMAPPED,        64'h0000_0000},
        '{ROW_BLOCK, REG_UNMAPPED,        64'h0001_fffe},
        '{ROW_WRITE, REG_UNMAPPED,        64'hffff_ffff_ffff_ffff},
        '{ROW_BLOCK, REG_UNMAPPED,        64'h0000_0000},
        '{ROW_WRITE, REG_ROUND_KEYS_LOW,  64'h0123_4567_89ab_cdef},
        '{ROW_WRITE, REG_ROUND_KEYS_HIGH, 64'hfedc_ba98_7654_3210},
        '{ROW_WRITE, REG_WHITENING_KEYS,  64'h0000_0000_a5a5_5a5a},
        '{ROW_BLOCK, REG_UNMAPPED,        64'h0000_0001},
        '{ROW_BLOCK, REG_UNMAPPED,        64'h7fff_ffff},
        '{ROW_BLOCK, REG_UNMAPPED,        64'hc3a5_965a},
        '{ROW_BLOCK, REG_UNMAPPED,        64'hfffe_0001}
    };

    feistel_block_encrypt_32 u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .plaintext  (plaintext),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ciphertext (ciphertext)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Round function: add up one S-box word per row, the column picked by
    // the matching two-bit slice of the input, wrapping at 16 bits.
    function automatic logic [HALF_W-1:0] sbox_sum(input logic [HALF_W-1:0] x);
        logic [HALF_W-1:0] total;
        logic [HALF_W-1:0] shifted;
        total   = '0;
        shifted = x;
        for (int row = 0; row < SBOX_ROWS; row++)
        begin
            total   = total + SBOX[row][shifted[1:0]];
            shifted = shifted >> 2;
        end
        return total;
    endfunction

    // Ciphertext of one block under the current keys.
    function automatic logic [31:0] encipher(input logic [31:0] blk);
        logic [HALF_W-1:0] lhalf;
        logic [HALF_W-1:0] rhalf;
        logic [HALF_W-1:0] held;
        logic [HALF_W-1:0] subkey;
        lhalf = blk[31:16];
        rhalf = blk[15:0];
        for (int rnd = 0; rnd < NUM_ROUNDS; rnd++)
        begin
            subkey = (rnd < 4) ? key_low[16*rnd +: 16] : key_high[16*(rnd-4) +: 16];
            lhalf  = lhalf ^ subkey;
            rhalf  = rhalf ^ sbox_sum(lhalf);
            held   = rhalf;
            rhalf  = lhalf;
            lhalf  = held;
        end
        lhalf = lhalf ^ white_keys[15:0];
        rhalf = rhalf ^ white_keys[31:16];
        return {lhalf, rhalf};
    endfunction

    task automatic flag_error(input string what, input logic [63:0] want,
                              input logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("ERROR %s: expected %h, got %h", what, want, got);
    endtask

    // Write transaction to one register, then read it back when it is mapped.
    task automatic program_register(input logic [1:0] idx, input logic [63:0] data);
        logic [63:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_ROUND_KEYS_LOW:
            begin
                key_low = data;
                want    = key_low;
            end
            REG_ROUND_KEYS_HIGH:
            begin
                key_high = data;
                want     = key_high;
            end
            REG_WHITENING_KEYS:
            begin
                white_keys = data[31:0];
                want       = {32'h0, white_keys};
            end
            default: want = '0;
        endcase
        if (idx != REG_UNMAPPED)
        begin
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            if (prdata !== want)
                flag_error("register read-back", want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one plaintext block after a random gap and hold it until accepted.
    // Ready is sampled in the middle of the cycle, where it has settled.
    task automatic send_block(input logic [31:0] blk);
        int gap;
        bit taken;
        if ($urandom_range(0, 63) == 0)
            in_calm = !in_calm;
        gap = in_calm ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        plaintext <= blk;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        ciphers_due.push_back('{blk, encipher(blk)});
    endtask

    // Stop offering blocks and wait until every ciphertext has come out.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (ciphers_due.size() != 0)
            @(posedge clk);
    endtask

    // Main sequence: reset, directed table, then random phases under new keys.
    initial
    begin
        logic [31:0] blk;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        in_valid   <= 1'b0;
        plaintext  <= '0;
        rst_n      <= 1'b0;
        key_low    = '0;
        key_high   = '0;
        white_keys = '0;
        mismatches = 0;
        in_calm    = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; keys change only with the pipeline empty.
        for (int row = 0; row < DIRECTED_ROWS; row++)
        begin
            if (directed_rows[row].kind == ROW_WRITE)
            begin
                drain_pipeline();
                program_register(directed_rows[row].idx, directed_rows[row].value);
            end
            else
                send_block(directed_rows[row].value[31:0]);
        end

        // Random phases, the first two with extreme keys.
        for (int phase = 0; phase < KEY_PHASES; phase++)
        begin
            drain_pipeline();
            case (phase)
                0:
                begin
                    program_register(REG_ROUND_KEYS_LOW, '1);
                    program_register(REG_ROUND_KEYS_HIGH, '1);
                    program_register(REG_WHITENING_KEYS, '0);
                end
                1:
                begin
                    program_register(REG_ROUND_KEYS_LOW, '0);
                    program_register(REG_ROUND_KEYS_HIGH, '0);
                    program_register(REG_WHITENING_KEYS, '1);
                end
                default:
                begin
                    program_register(REG_ROUND_KEYS_LOW, {$urandom, $urandom});
                    program_register(REG_ROUND_KEYS_HIGH, {$urandom, $urandom});
                    program_register(REG_WHITENING_KEYS, {$urandom, $urandom});
                    if (phase == 3)
                        program_register(REG_UNMAPPED, {$urandom, $urandom});
                end
            endcase
            for (int n = 0; n < BLOCKS_PER_PHASE; n++)
            begin
                case ($urandom_range(0, 7))
                    0:       blk = '0;
                    1:       blk = '1;
                    2:       blk = 32'h1 << $urandom_range(0, 31);
                    3:       blk = ~(32'h1 << $urandom_range(0, 31));
                    default: blk = $urandom;
                endcase
                send_block(blk);
            end
        end

        drain_pipeline();
        repeat (PIPE_DEPTH + 4) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Consumer: stall a random number of cycles before taking each result.
    initial
    begin
        int stall;
        bit out_calm;
        bit taken;
        out_ready <= 1'b0;
        out_calm  = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                out_calm = !out_calm;
            stall = out_calm ? 0 : $urandom_range(0, 5);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(negedge clk);
                taken = out_valid;
                @(posedge clk);
            end
            while (!taken);
        end
    end

    // Compare each ciphertext transaction with the oldest block in flight.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (ciphers_due.size() == 0)
                flag_error("ciphertext with no block in flight", '0, {32'h0, ciphertext});
            else
            begin
                oldest_due = ciphers_due.pop_front();
                if (ciphertext !== oldest_due.cipher)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("ERROR ciphertext of %h: expected %h, got %h",
                                 oldest_due.plain, oldest_due.cipher, ciphertext);
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
